// File: rtl/core/psba_pkg.sv
// ----------------------------------------------------------------------------
// Preferred-slot bitmap allocator package
// Shared word geometry, register map and grant status codes.
// ----------------------------------------------------------------------------
package psba_pkg;

	localparam int SLOT_WORD_W = 16;
	localparam int SLOT_BIT_W  = 4;
	localparam int COUNT_W     = 9;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = 9'd200;

	localparam logic REG_SLOT_COUNT = 1'b0;

	typedef enum logic [1:0] {
		GRANT_WANTED = 2'd0,
		GRANT_LOWEST = 2'd1,
		GRANT_NONE   = 2'd2
	} grant_status_t;

endpackage

// File: rtl/core/preferred_slot_bitmap_allocator.sv
// Each scan of the free map reads one 16-slot word per cycle from the bitmap memory: one
// scan finds a free slot when the wanted slot is out of range or not free, another advances
// the lowest-free pointer after a grant. One transaction at a time; the next request is taken
// in the cycle after the result is registered, which waits while the previous response is
// still held. Reset sets slot_count to 200 and marks every slot free at once through per-word
// valid flags.
// ----------------------------------------------------------------------------
// Preferred-slot bitmap allocator
// Grants the requested slot when free, else the lowest free slot (or reports none), from a
// word-organised free map held in a synchronous memory.
// ----------------------------------------------------------------------------
module preferred_slot_bitmap_allocator #(
	parameter int MAX_SLOTS = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [psba_pkg::PADDR_W-1:0]     paddr,
	input  logic [psba_pkg::PDATA_W-1:0]     pwdata,
	output logic [psba_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [psba_pkg::COUNT_W-1:0]     wanted_slot,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output psba_pkg::grant_status_t          grant_status,
	output logic [psba_pkg::COUNT_W-1:0]     granted_slot
);
	import psba_pkg::*;

	localparam int WORDS = (MAX_SLOTS + SLOT_WORD_W - 1) / SLOT_WORD_W;
	localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int LW    = $clog2(MAX_SLOTS + 2);
	localparam int XW    = ((LW > COUNT_W) ? LW : COUNT_W) + 2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WCHK,
		S_SCAN,
		S_ADV,
		S_EMIT
	} state_t;

	state_t                  state_q;
	logic                    adv_mode_q;
	logic [COUNT_W-1:0]      slot_count_q;
	logic [COUNT_W-1:0]      want_q;
	logic [LW-1:0]           lowest_q;
	grant_status_t           res_status_q;
	logic [COUNT_W-1:0]      res_slot_q;
	logic                    rsp_valid_q;
	grant_status_t           rsp_status_q;
	logic [COUNT_W-1:0]      rsp_slot_q;
	logic [WA-1:0]           ra_q;
	logic [WORDS-1:0]        word_valid_q;

	logic [SLOT_WORD_W-1:0]  mem [WORDS];
	logic [SLOT_WORD_W-1:0]  rd_data_s1;
	logic [WA-1:0]           rd_word_s1;
	logic                    rd_valid_s1;

	logic [XW-1:0]           n_x;
	logic [XW-1:0]           lowest_x;
	logic [XW-1:0]           req_x;
	logic [XW-1:0]           want_m1_x;
	logic [XW-1:0]           base_x;
	logic [XW-1:0]           found_slot_x;
	logic                    req_ok;
	logic                    low_gt_n;
	logic [SLOT_WORD_W-1:0]  eff;
	logic [SLOT_WORD_W-1:0]  mask;
	logic [SLOT_WORD_W-1:0]  cand;
	logic [SLOT_WORD_W-1:0]  clr_mask;
	logic [SLOT_BIT_W-1:0]   want_bit;
	logic [SLOT_BIT_W-1:0]   found_bit;
	logic                    want_free;
	logic                    found;
	logic                    word_end;
	logic                    wr_en;
	logic [WA-1:0]           rd_addr;
	logic [WA-1:0]           ra_next;
	logic                    rsp_load;
	logic                    cfg_write;

	function automatic logic [WA-1:0] word_of(input logic [XW-1:0] slot);
		logic [XW-1:0] idx;
		idx = (slot - XW'(1)) >> SLOT_BIT_W;
		if (idx > XW'(WORDS - 1)) begin
			idx = XW'(WORDS - 1);
		end
		return idx[WA-1:0];
	endfunction

	// Configuration port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (paddr[2] == REG_SLOT_COUNT) ? PDATA_W'(slot_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= SLOT_COUNT_RST;
		end else if (cfg_write && paddr[2] == REG_SLOT_COUNT) begin
			slot_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	// Bounds and request decode
	always_comb begin
		n_x = XW'(slot_count_q);
		if (n_x > XW'(MAX_SLOTS)) begin
			n_x = XW'(MAX_SLOTS);
		end
	end

	assign lowest_x  = XW'(lowest_q);
	assign req_x     = XW'(wanted_slot);
	assign req_ok    = (req_x != '0) && (req_x <= n_x);
	assign low_gt_n  = lowest_x > n_x;
	assign want_m1_x = XW'(want_q) - XW'(1);
	assign want_bit  = want_m1_x[SLOT_BIT_W-1:0];

	// Word evaluation on the registered read data
	assign eff       = rd_valid_s1 ? rd_data_s1 : '1;
	assign want_free = eff[want_bit];
	assign base_x    = XW'({rd_word_s1, {SLOT_BIT_W{1'b0}}}) + XW'(1);
	assign word_end  = (base_x + XW'(SLOT_WORD_W - 1)) >= n_x;

	always_comb begin
		for (int b = 0; b < SLOT_WORD_W; b++) begin
			mask[b] = ((base_x + XW'(b)) >= lowest_x) && ((base_x + XW'(b)) <= n_x);
		end
	end

	assign cand = eff & mask;

	always_comb begin
		found_bit = '0;
		for (int b = SLOT_WORD_W - 1; b >= 0; b--) begin
			if (cand[b]) begin
				found_bit = SLOT_BIT_W'(b);
			end
		end
	end

	assign found        = |cand;
	assign found_slot_x = base_x + XW'(found_bit);

	// Read-modify-write of the free map
	always_comb begin
		wr_en    = 1'b0;
		clr_mask = '0;
		if (state_q == S_WCHK && want_free) begin
			wr_en    = 1'b1;
			clr_mask = SLOT_WORD_W'(1) << want_bit;
		end else if (state_q == S_SCAN && !adv_mode_q && found) begin
			wr_en    = 1'b1;
			clr_mask = SLOT_WORD_W'(1) << found_bit;
		end
	end

	always_comb begin
		unique case (state_q)
			S_IDLE: begin
				rd_addr = req_ok ? word_of(req_x) : word_of(lowest_x);
			end
			S_WCHK, S_ADV: begin
				rd_addr = word_of(lowest_x);
			end
			S_SCAN, S_EMIT: begin
				rd_addr = ra_q;
			end
			default: begin
				rd_addr = ra_q;
			end
		endcase
	end

	assign ra_next = (rd_addr == WA'(WORDS - 1)) ? rd_addr : rd_addr + WA'(1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[rd_word_s1] <= eff & ~clr_mask;
		end
		rd_data_s1  <= mem[rd_addr];
		rd_word_s1  <= rd_addr;
		rd_valid_s1 <= word_valid_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid_q <= '0;
			ra_q         <= '0;
		end else begin
			ra_q <= ra_next;
			if (wr_en) begin
				word_valid_q[rd_word_s1] <= 1'b1;
			end
		end
	end

	// Sequencer and result register
	assign req_ready = (state_q == S_IDLE);
	assign rsp_load  = (state_q == S_EMIT) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			adv_mode_q   <= 1'b0;
			want_q       <= '0;
			lowest_q     <= LW'(1);
			res_status_q <= GRANT_NONE;
			res_slot_q   <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= GRANT_NONE;
			rsp_slot_q   <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						want_q     <= wanted_slot;
						adv_mode_q <= 1'b0;
						if (req_ok) begin
							state_q <= S_WCHK;
						end else if (low_gt_n) begin
							res_status_q <= GRANT_NONE;
							res_slot_q   <= '0;
							state_q      <= S_EMIT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_WCHK: begin
					if (want_free) begin
						res_status_q <= GRANT_WANTED;
						res_slot_q   <= want_q;
						state_q      <= S_ADV;
					end else if (low_gt_n) begin
						res_status_q <= GRANT_NONE;
						res_slot_q   <= '0;
						state_q      <= S_EMIT;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!adv_mode_q) begin
						if (found) begin
							res_status_q <= GRANT_LOWEST;
							res_slot_q   <= found_slot_x[COUNT_W-1:0];
							state_q      <= S_ADV;
						end else if (word_end) begin
							res_status_q <= GRANT_NONE;
							res_slot_q   <= '0;
							state_q      <= S_EMIT;
						end
					end else begin
						if (found) begin
							lowest_q <= found_slot_x[LW-1:0];
							state_q  <= S_EMIT;
						end else if (word_end) begin
							lowest_q <= LW'(n_x + XW'(1));
							state_q  <= S_EMIT;
						end
					end
				end
				S_ADV: begin
					adv_mode_q <= 1'b1;
					state_q    <= low_gt_n ? S_EMIT : S_SCAN;
				end
				S_EMIT: begin
					if (rsp_load) begin
						rsp_status_q <= res_status_q;
						rsp_slot_q   <= res_slot_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign grant_status = rsp_status_q;
	assign granted_slot = rsp_slot_q;

`ifndef NO_ASSERTIONS
	a_no_double_grant: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (eff & clr_mask) != '0)
		else $error("slot granted twice");

	a_lowest_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> lowest_q >= $past(lowest_q))
		else $error("lowest free pointer moved backwards");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_status_q == GRANT_NONE) |-> rsp_slot_q == '0)
		else $error("no-slot result carries a slot number");

	a_grant_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_status_q != GRANT_NONE) |->
			(rsp_slot_q != '0 && XW'(rsp_slot_q) <= n_x))
		else $error("granted slot outside the slot range");

	a_wanted_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_load && res_status_q == GRANT_WANTED) |-> res_slot_q == want_q)
		else $error("wanted grant does not match the request");
`endif

endmodule
